// File: rtl/midi_clock_generator_assert.svh
// ----------------------------------------------------------------------------
// MIDI clock generator assertion macros
// Shared property wrappers; each expects clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef MIDI_CLOCK_GENERATOR_ASSERT_SVH
`define MIDI_CLOCK_GENERATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MCG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// MIDI clock generator package
// Transaction types, message codes, microcode word layout and control store.
// ----------------------------------------------------------------------------
package mcg_pkg;

    // configuration and sizing
    localparam int MaxBurstDef = 56;
    localparam int UpcW        = 5;
    localparam int CfgIdxW     = 2;
    localparam int CfgDataW    = 32;

    localparam logic [CfgIdxW-1:0] CFG_OFFSET  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SPP_EN  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_CLK = 2'd2;

    localparam logic signed [31:0] OFFSET_RST  = 32'sd0;
    localparam logic               SPP_EN_RST  = 1'b1;
    localparam logic [5:0]         MAX_CLK_RST = 6'd56;

    // clocks sent to reach a negative start position are also capped here
    localparam logic [5:0]  PLAY_CLK_MAX = 6'd59;
    localparam logic [31:0] Q16_ONE      = 32'h0001_0000;

    // update kinds
    localparam logic [1:0] KIND_POLL  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_PLAY  = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    // MIDI status bytes
    localparam logic [7:0] ST_CLOCK = 8'hF8;
    localparam logic [7:0] ST_START = 8'hFA;
    localparam logic [7:0] ST_CONT  = 8'hFB;
    localparam logic [7:0] ST_STOP  = 8'hFC;
    localparam logic [7:0] ST_SPP   = 8'hF2;
    localparam logic [1:0] SPP_DATA_CNT = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] position;
        logic               play_on;
        logic               force_restart;
        logic               transport_playing;
    } mcg_in_t;

    typedef struct packed {
        logic        msg_valid;
        logic [7:0]  status_byte;
        logic [6:0]  data_lsb;
        logic [6:0]  data_msb;
        logic [1:0]  data_count;
        logic [31:0] wait_pulses;
        logic        last;
    } mcg_out_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_SUM,
        OP_TGT,
        OP_TRUNC,
        OP_BEATCHK,
        OP_PC_B6,
        OP_NPLAY,
        OP_DEC_N,
        OP_PLAY_B6,
        OP_PLAY_ZERO,
        OP_PLAY_OFF,
        OP_DIFF,
        OP_NCAP,
        OP_PCADD,
        OP_WAIT,
        OP_START,
        OP_STOP
    } mcg_op_t;

    // message emitted by a step
    typedef enum logic [2:0] {
        EM_NONE,
        EM_CLK,
        EM_START,
        EM_STOP,
        EM_SPP,
        EM_STCONT
    } mcg_emit_t;

    // branch conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_KIND_POLL,
        C_KIND_START,
        C_KIND_STOP,
        C_NOT_RUN,
        C_NO_JUMP,
        C_SAME,
        C_NOT_TPLAY,
        C_N_ZERO,
        C_N_GT1,
        C_PLAY_OFF,
        C_NO_SPP
    } mcg_cond_t;

    typedef struct packed {
        mcg_op_t         op;
        mcg_emit_t       emit;
        mcg_cond_t       cond;
        logic [UpcW-1:0] target;
        logic            fin;
    } mcg_uword_t;

    // sequencer to datapath
    typedef struct packed {
        logic      load;
        logic      go;
        logic      fin;
        mcg_op_t   op;
        mcg_emit_t emit;
    } mcg_ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic [1:0] kind;
        logic       running;
        logic       jump_ok;
        logic       same;
        logic       tplay;
        logic       play_on;
        logic       spp_en;
        logic       n_zero;
        logic       n_gt1;
        logic       pend_valid;
        logic       out_free;
    } mcg_stat_t;

    // branch targets in the control store
    localparam logic [UpcW-1:0] L_JUMP_SPP   = 5'd7;
    localparam logic [UpcW-1:0] L_PLAY       = 5'd9;
    localparam logic [UpcW-1:0] L_PLAY_CLK   = 5'd11;
    localparam logic [UpcW-1:0] L_PLAY_SPP   = 5'd12;
    localparam logic [UpcW-1:0] L_PLAY_NOSPP = 5'd15;
    localparam logic [UpcW-1:0] L_PLAY_OFF   = 5'd16;
    localparam logic [UpcW-1:0] L_POLL       = 5'd17;
    localparam logic [UpcW-1:0] L_POLL_CLK   = 5'd22;
    localparam logic [UpcW-1:0] L_END        = 5'd23;
    localparam logic [UpcW-1:0] L_START      = 5'd24;
    localparam logic [UpcW-1:0] L_STOP       = 5'd25;
    localparam logic [UpcW-1:0] L_ENTRY      = 5'd0;

    function automatic mcg_uword_t uw(input mcg_op_t op, input mcg_emit_t em,
                                      input mcg_cond_t cnd,
                                      input logic [UpcW-1:0] tgt, input logic fin);
        mcg_uword_t w;
        w.op     = op;
        w.emit   = em;
        w.cond   = cnd;
        w.target = tgt;
        w.fin    = fin;
        return w;
    endfunction

    // control store
    function automatic mcg_uword_t mcg_ucode(input logic [UpcW-1:0] addr);
        mcg_uword_t w;
        case (addr)
            // common front end: offset sum, target, truncated pulse count
            5'd0:  w = uw(OP_SUM,       EM_NONE,   C_KIND_STOP,  L_STOP,       1'b0);
            5'd1:  w = uw(OP_TGT,       EM_NONE,   C_KIND_POLL,  L_POLL,       1'b0);
            5'd2:  w = uw(OP_TRUNC,     EM_NONE,   C_KIND_START, L_START,      1'b0);
            // play change: jump handling
            5'd3:  w = uw(OP_BEATCHK,   EM_NONE,   C_NO_JUMP,    L_PLAY,       1'b0);
            5'd4:  w = uw(OP_NONE,      EM_NONE,   C_SAME,       L_END,        1'b0);
            5'd5:  w = uw(OP_NONE,      EM_NONE,   C_NOT_TPLAY,  L_JUMP_SPP,   1'b0);
            5'd6:  w = uw(OP_NONE,      EM_STOP,   C_NEVER,      L_END,        1'b0);
            5'd7:  w = uw(OP_PC_B6,     EM_SPP,    C_NOT_TPLAY,  L_PLAY,       1'b0);
            5'd8:  w = uw(OP_NONE,      EM_STCONT, C_NEVER,      L_END,        1'b0);
            // play on / off
            5'd9:  w = uw(OP_NPLAY,     EM_NONE,   C_PLAY_OFF,   L_PLAY_OFF,   1'b0);
            5'd10: w = uw(OP_NONE,      EM_NONE,   C_N_ZERO,     L_PLAY_SPP,   1'b0);
            5'd11: w = uw(OP_DEC_N,     EM_CLK,    C_N_GT1,      L_PLAY_CLK,   1'b0);
            5'd12: w = uw(OP_NONE,      EM_NONE,   C_NO_SPP,     L_PLAY_NOSPP, 1'b0);
            5'd13: w = uw(OP_NONE,      EM_SPP,    C_NEVER,      L_END,        1'b0);
            5'd14: w = uw(OP_PLAY_B6,   EM_STCONT, C_ALWAYS,     L_END,        1'b0);
            5'd15: w = uw(OP_PLAY_ZERO, EM_START,  C_ALWAYS,     L_END,        1'b0);
            5'd16: w = uw(OP_PLAY_OFF,  EM_STOP,   C_ALWAYS,     L_END,        1'b0);
            // poll
            5'd17: w = uw(OP_DIFF,      EM_NONE,   C_NOT_RUN,    L_END,        1'b0);
            5'd18: w = uw(OP_NCAP,      EM_NONE,   C_NEVER,      L_END,        1'b0);
            5'd19: w = uw(OP_PCADD,     EM_NONE,   C_NEVER,      L_END,        1'b0);
            5'd20: w = uw(OP_DIFF,      EM_NONE,   C_NEVER,      L_END,        1'b0);
            5'd21: w = uw(OP_WAIT,      EM_NONE,   C_N_ZERO,     L_END,        1'b0);
            5'd22: w = uw(OP_DEC_N,     EM_CLK,    C_N_GT1,      L_POLL_CLK,   1'b0);
            // close the transaction
            5'd23: w = uw(OP_NONE,      EM_NONE,   C_NEVER,      L_END,        1'b1);
            5'd24: w = uw(OP_START,     EM_NONE,   C_ALWAYS,     L_END,        1'b0);
            5'd25: w = uw(OP_STOP,      EM_NONE,   C_ALWAYS,     L_END,        1'b0);
            default: w = uw(OP_NONE,    EM_NONE,   C_NEVER,      L_END,        1'b1);
        endcase
        return w;
    endfunction

endpackage

// File: rtl/mcg_seq.sv
// ----------------------------------------------------------------------------
// MIDI clock generator sequencer
// Step counter over the control store with conditional branches and stalls.
// ----------------------------------------------------------------------------
`include "midi_clock_generator_assert.svh"

module mcg_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  mcg_pkg::mcg_stat_t stat,
    output mcg_pkg::mcg_ctl_t  ctl
);
    import mcg_pkg::*;

    logic            busy_reg, busy_next;
    logic [UpcW-1:0] upc_reg, upc_next;
    mcg_uword_t      word;
    logic            load;
    logic            blocked;
    logic            go;
    logic            taken;

    assign word     = mcg_ucode(upc_reg);
    assign in_stall = busy_reg;
    assign load     = in_valid && !busy_reg;

    // a message step needs room to retire the held message, the end step
    // needs the output register
    assign blocked = ((word.emit != EM_NONE) && stat.pend_valid && !stat.out_free)
                  || (word.fin && !stat.out_free);
    assign go      = busy_reg && !blocked;

    // branch condition
    always_comb
    begin
        unique case (word.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_KIND_POLL:  taken = (stat.kind == KIND_POLL);
            C_KIND_START: taken = (stat.kind == KIND_START);
            C_KIND_STOP:  taken = (stat.kind == KIND_STOP);
            C_NOT_RUN:    taken = !stat.running;
            C_NO_JUMP:    taken = !stat.jump_ok;
            C_SAME:       taken = stat.same;
            C_NOT_TPLAY:  taken = !stat.tplay;
            C_N_ZERO:     taken = stat.n_zero;
            C_N_GT1:      taken = stat.n_gt1;
            C_PLAY_OFF:   taken = !stat.play_on;
            C_NO_SPP:     taken = !stat.spp_en;
            default:      taken = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (load)
        begin
            busy_next = 1'b1;
            upc_next  = L_ENTRY;
        end
        else if (go)
        begin
            if (word.fin)
                busy_next = 1'b0;
            else if (taken)
                upc_next = word.target;
            else
                upc_next = upc_reg + UpcW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= L_ENTRY;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    always_comb
    begin
        ctl.load = load;
        ctl.go   = go;
        ctl.fin  = word.fin;
        ctl.op   = word.op;
        ctl.emit = word.emit;
    end

    `MCG_ASSERT_NEXT(a_load_enters, load, busy_reg && (upc_reg == L_ENTRY), "load did not start the program")
    `MCG_ASSERT_NEXT(a_fin_idles, go && word.fin, !busy_reg, "end step left the sequencer busy")

endmodule

// File: rtl/mcg_dp.sv
// ----------------------------------------------------------------------------
// MIDI clock generator datapath
// Target arithmetic, pulse counter, message build, hold and output register.
// ----------------------------------------------------------------------------
`include "midi_clock_generator_assert.svh"

module mcg_dp #(
    parameter int MAX_BURST = mcg_pkg::MaxBurstDef
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcg_pkg::mcg_in_t    in_item,
    input  mcg_pkg::mcg_ctl_t   ctl,
    input  logic signed [31:0]  offset,
    input  logic                spp_en,
    input  logic [5:0]          max_clocks,
    input  logic                out_stall,
    output logic                out_valid,
    output mcg_pkg::mcg_out_t   out_item,
    output mcg_pkg::mcg_stat_t  stat
);
    import mcg_pkg::*;

    localparam logic [5:0] BurstMax = 6'(MAX_BURST);

    // transaction and working registers
    mcg_in_t            in_reg;
    logic signed [32:0] sum_reg, sum_next;
    logic signed [17:0] beat_reg, beat_next;
    logic signed [37:0] tgt_reg, tgt_next;
    logic signed [20:0] b6_reg, b6_next;
    logic signed [21:0] tq_reg, tq_next;
    logic signed [48:0] diff_reg, diff_next;
    logic [5:0]         n_reg, n_next;
    logic [31:0]        wait_reg, wait_next;
    logic               same_reg, same_next;
    // architectural state
    logic [31:0]        pc_reg, pc_next;
    logic               running_reg, running_next;
    logic               playing_reg, playing_next;
    // message hold and output register
    logic               pend_valid_reg, pend_valid_next;
    mcg_out_t           pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    mcg_out_t           out_reg, out_next;

    // combinational helpers
    logic [37:0]        t16, t8;
    logic [20:0]        b4, b2;
    logic [32:0]        nq;
    logic [48:0]        diff_neg;
    logic signed [32:0] cnt_x, b6_x, lo, hi;
    logic               beat_pos, beat_neg;
    logic [21:0]        tq_neg;
    logic [5:0]         cap, cap59, ncap_val, nplay_val;
    logic [31:0]        wait_val;
    mcg_out_t           msg, fin_item;
    logic               emit_act, out_free, push;

    // burst limits
    assign cap   = (max_clocks > BurstMax) ? BurstMax : max_clocks;
    assign cap59 = (cap > PLAY_CLK_MAX) ? PLAY_CLK_MAX : cap;

    // sum * 24 as sum * 16 + sum * 8, beat * 6 as beat * 4 + beat * 2
    assign t16 = {sum_reg[32], sum_reg, 4'b0};
    assign t8  = {sum_reg[32], sum_reg[32], sum_reg, 3'b0};
    assign b4  = {beat_reg[17], beat_reg, 2'b0};
    assign b2  = {beat_reg[17], beat_reg[17], beat_reg, 1'b0};

    // pulses the target is ahead of the counter, floored
    assign nq       = diff_reg[48:16];
    assign ncap_val = diff_reg[48] ? 6'd0 :
                      ((nq[32:6] != '0) || (nq[5:0] > cap)) ? cap : nq[5:0];

    // wait to the next pulse in Q16 pulses, saturated
    assign diff_neg = -diff_reg;
    always_comb
    begin
        if (diff_reg[48])
            wait_val = (diff_neg[48:32] != '0) ? '1 : diff_neg[31:0];
        else if (nq == '0)
            wait_val = Q16_ONE - {16'd0, diff_reg[15:0]};
        else
            wait_val = '0;
    end

    // same sixteenth: count / 6 == beat, truncating toward zero
    assign beat_pos = !beat_reg[17] && (beat_reg != '0);
    assign beat_neg = beat_reg[17];
    assign cnt_x    = {pc_reg[31], pc_reg};
    assign b6_x     = {{12{b6_reg[20]}}, b6_reg};
    assign lo       = beat_pos ? b6_x : b6_x - 33'sd5;
    assign hi       = beat_neg ? b6_x : b6_x + 33'sd5;

    // catch-up clocks ahead of a negative start position
    assign tq_neg    = -tq_reg;
    assign nplay_val = !tq_reg[21] ? 6'd0 :
                       ((tq_neg[21:6] != '0) || (tq_neg[5:0] > cap59)) ? cap59 : tq_neg[5:0];

    // operation execute
    always_comb
    begin
        sum_next     = sum_reg;
        beat_next    = beat_reg;
        tgt_next     = tgt_reg;
        b6_next      = b6_reg;
        tq_next      = tq_reg;
        diff_next    = diff_reg;
        n_next       = n_reg;
        wait_next    = wait_reg;
        same_next    = same_reg;
        pc_next      = pc_reg;
        running_next = running_reg;
        playing_next = playing_reg;
        if (ctl.load)
            wait_next = '0;
        if (ctl.go)
        begin
            unique case (ctl.op)
                OP_NONE: ;
                OP_SUM:
                begin
                    sum_next  = {in_reg.position[31], in_reg.position}
                              + {offset[31], offset};
                    beat_next = in_reg.position[31:14]
                              + 18'(in_reg.position[31] && (in_reg.position[13:0] != '0));
                end
                OP_TGT:
                begin
                    tgt_next = t16 + t8;
                    b6_next  = b4 + b2;
                end
                OP_TRUNC:
                    tq_next = tgt_reg[37:16] + 22'(tgt_reg[37] && (tgt_reg[15:0] != '0));
                OP_BEATCHK:
                    same_next = (cnt_x >= lo) && (cnt_x <= hi);
                OP_PC_B6:
                    pc_next = {{11{b6_reg[20]}}, b6_reg};
                OP_NPLAY:
                    n_next = nplay_val;
                OP_DEC_N:
                    n_next = n_reg - 6'd1;
                OP_PLAY_B6:
                begin
                    pc_next      = {{11{b6_reg[20]}}, b6_reg};
                    playing_next = 1'b1;
                end
                OP_PLAY_ZERO:
                begin
                    pc_next      = '0;
                    playing_next = 1'b1;
                end
                OP_PLAY_OFF:
                    playing_next = 1'b0;
                OP_DIFF:
                    diff_next = {{11{tgt_reg[37]}}, tgt_reg} - {pc_reg[31], pc_reg, 16'b0};
                OP_NCAP:
                    n_next = ncap_val;
                OP_PCADD:
                    pc_next = pc_reg + {26'd0, n_reg};
                OP_WAIT:
                    wait_next = wait_val;
                OP_START:
                begin
                    pc_next      = {{10{tq_reg[21]}}, tq_reg};
                    running_next = 1'b1;
                end
                OP_STOP:
                    running_next = 1'b0;
                default: ;
            endcase
        end
    end

    // message for this step
    always_comb
    begin
        msg             = '0;
        msg.msg_valid   = 1'b1;
        msg.wait_pulses = wait_reg;
        unique case (ctl.emit)
            EM_CLK:    msg.status_byte = ST_CLOCK;
            EM_START:  msg.status_byte = ST_START;
            EM_STOP:   msg.status_byte = ST_STOP;
            EM_STCONT: msg.status_byte = beat_pos ? ST_CONT : ST_START;
            EM_SPP:
            begin
                msg.status_byte = ST_SPP;
                msg.data_lsb    = beat_reg[6:0];
                msg.data_msb    = beat_reg[13:7];
                msg.data_count  = SPP_DATA_CNT;
            end
            default:   msg.msg_valid = 1'b0;
        endcase
    end

    // closing transaction: held message or an empty result
    always_comb
    begin
        if (pend_valid_reg)
        begin
            fin_item      = pend_reg;
            fin_item.last = 1'b1;
        end
        else
        begin
            fin_item             = '0;
            fin_item.wait_pulses = wait_reg;
            fin_item.last        = 1'b1;
        end
    end

    // hold stage and output register
    assign emit_act = ctl.go && (ctl.emit != EM_NONE);
    assign out_free = !out_valid_reg || !out_stall;
    assign push     = (emit_act && pend_valid_reg) || (ctl.go && ctl.fin);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (emit_act)
        begin
            pend_valid_next = 1'b1;
            pend_next       = msg;
        end
        else if (ctl.go && ctl.fin)
            pend_valid_next = 1'b0;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = ctl.fin ? fin_item : pend_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            running_reg    <= 1'b0;
            playing_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            running_reg    <= running_next;
            playing_reg    <= playing_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            in_reg <= in_item;
        sum_reg  <= sum_next;
        beat_reg <= beat_next;
        tgt_reg  <= tgt_next;
        b6_reg   <= b6_next;
        tq_reg   <= tq_next;
        diff_reg <= diff_next;
        n_reg    <= n_next;
        wait_reg <= wait_next;
        same_reg <= same_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        stat.kind       = in_reg.kind;
        stat.running    = running_reg;
        stat.jump_ok    = in_reg.force_restart && spp_en;
        stat.same       = same_reg;
        stat.tplay      = in_reg.transport_playing;
        stat.play_on    = in_reg.play_on;
        stat.spp_en     = spp_en;
        stat.n_zero     = (n_reg == '0);
        stat.n_gt1      = (n_reg > 6'd1);
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    `MCG_ASSERT_NOW(a_no_overwrite, push && out_valid_reg, !out_stall, "result overwritten while stalled")
    `MCG_ASSERT_NOW(a_count_nonzero, ctl.go && (ctl.op == OP_DEC_N), n_reg != '0, "clock loop ran past zero")
    `MCG_ASSERT_NEXT(a_fin_last, ctl.go && ctl.fin, out_valid_reg && out_reg.last, "transaction closed without last")
    `MCG_ASSERT_NEXT(a_play_kind, in_reg.kind != KIND_PLAY, $stable(playing_reg), "play state changed outside a play change")

endmodule

// File: rtl/midi_clock_generator.sv
// ----------------------------------------------------------------------------
// MIDI clock generator
// Transport updates in, MIDI beat clock / song position messages out.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item) takes one transport update per
// transaction. Output channel (out_valid / out_stall / out_item) returns the
// messages that update causes, one per transaction; the final one has last set.
// An update that sends nothing returns one result with msg_valid low.
// A small microcoded sequencer runs one update at a time: in_stall is high
// from acceptance until the final result is registered. Messages leave at
// one per cycle while the receiver takes them; each is held one step and is
// registered with the next message or at the end step.
// A stalled receiver holds the output register and freezes the sequencer at
// its next message or end step; nothing is lost or repeated.
// Reset clears the pulse counter and the running and playing flags, and
// loads the registers: offset 0, song position enabled, burst limit register 56.
// Registers are written through cfg_wr_en / cfg_index / cfg_wdata; the user
// must write them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module midi_clock_generator #(
    parameter int MAX_BURST = mcg_pkg::MaxBurstDef
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  mcg_pkg::mcg_in_t               in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output mcg_pkg::mcg_out_t              out_item,
    input  logic                           cfg_wr_en,
    input  logic [mcg_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [mcg_pkg::CfgDataW-1:0]   cfg_wdata
);
    import mcg_pkg::*;

    logic signed [31:0] offset_reg, offset_next;
    logic               spp_en_reg, spp_en_next;
    logic [5:0]         max_clk_reg, max_clk_next;
    mcg_ctl_t           ctl;
    mcg_stat_t          stat;

    // configuration register decode
    always_comb
    begin
        offset_next  = offset_reg;
        spp_en_next  = spp_en_reg;
        max_clk_next = max_clk_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_OFFSET:  offset_next  = cfg_wdata;
                CFG_SPP_EN:  spp_en_next  = cfg_wdata[0];
                CFG_MAX_CLK: max_clk_next = cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= OFFSET_RST;
            spp_en_reg  <= SPP_EN_RST;
            max_clk_reg <= MAX_CLK_RST;
        end
        else
        begin
            offset_reg  <= offset_next;
            spp_en_reg  <= spp_en_next;
            max_clk_reg <= max_clk_next;
        end
    end

    mcg_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    mcg_dp #(
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .ctl        (ctl),
        .offset     (offset_reg),
        .spp_en     (spp_en_reg),
        .max_clocks (max_clk_reg),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_item   (out_item),
        .stat       (stat)
    );

endmodule

// File: tb/sv/tb_midi_clock_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock generator testbench
// Drives transport updates through the valid/stall channels and scores every
// message against a cycle-free model of the clock generator. The run opens
// with a short scripted sequence, then goes through several register
// settings, each with randomized transport sessions (start, play, polls,
// jumps, stop) mixed with random updates. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_midi_clock_generator;
    import mcg_pkg::*;

    localparam longint     QONE          = 64'sd65536;
    localparam logic [7:0] ST_NONE       = 8'h00;
    localparam int         RESET_CYCLES  = 5;
    localparam int         IDLE_LIMIT    = 4000;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         DRAIN_CYCLES  = 120;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         PHASE_ITEMS   = 58;
    localparam int         NUM_PHASES    = 6;

    // scripted update; typed rows carry a single empty result with the given wait
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] pos;
        logic        play_on;
        logic        force_rs;
        logic        tplay;
        logic        typed;
        logic [31:0] idle_wait;
    } script_row_t;

    localparam int SCRIPT_LEN = 24;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // not running yet: empty results
        '{KIND_POLL,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        '{KIND_STOP,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000},
        '{KIND_START, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000},
        // on target: one pulse to wait
        '{KIND_POLL,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0001_0000},
        '{KIND_POLL,  32'h0001_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        // far ahead: burst capped
        '{KIND_POLL,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        // far behind: saturated wait
        '{KIND_POLL,  32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
        '{KIND_POLL,  32'h0001_0800, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        // play on, then a jump inside the same sixteenth
        '{KIND_PLAY,  32'h0002_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{KIND_PLAY,  32'h0002_3000, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        // real jumps while playing and while stopped, and back to zero
        '{KIND_PLAY,  32'h0003_0000, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{KIND_PLAY,  32'h0005_0000, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0},
        '{KIND_PLAY,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        // negative start positions: catch-up clocks and wrapped song position
        '{KIND_PLAY,  32'hFFFF_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{KIND_PLAY,  32'hFFFE_0000, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{KIND_PLAY,  32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{KIND_PLAY,  32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{KIND_PLAY,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        // start below zero, then polls across zero
        '{KIND_START, 32'hFFFF_8000, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000},
        '{KIND_POLL,  32'hFFFF_C000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{KIND_POLL,  32'hFFFF_C000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{KIND_POLL,  32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{KIND_STOP,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        '{KIND_POLL,  32'h0001_0000, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    mcg_in_t              in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    mcg_out_t             out_item;
    logic                 cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_wdata = '0;

    // side information that travels with the offered update
    logic                 row_typed = 1'b0;
    mcg_out_t             row_msg   = '0;

    // generator model state and register copies
    logic [31:0]          pc_model   = '0;
    logic                 run_model  = 1'b0;
    logic                 play_model = 1'b0;
    logic signed [31:0]   offs_cfg   = OFFSET_RST;
    logic                 spp_cfg    = SPP_EN_RST;
    logic [5:0]           maxclk_cfg = MAX_CLK_RST;

    mcg_out_t             step_msgs[$];
    mcg_out_t             msg_q[$];
    int                   fail_count  = 0;
    int                   items_sent  = 0;
    int                   idle_cycles = 0;
    bit                   calm        = 1'b0;
    bit                   hold_req    = 1'b0;

    midi_clock_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // clock generator model
    // ------------------------------------------------------------------
    function automatic longint floor_pulses(input longint v);
        if (v >= 0)
            return v / QONE;
        return -((-v + (QONE - 1)) / QONE);
    endfunction

    function automatic logic [31:0] clamp_wait(input longint w);
        if (w < 0)
            return '0;
        if (w > 64'sd4294967295)
            return '1;
        return w[31:0];
    endfunction

    function automatic longint burst_limit();
        if (maxclk_cfg > MaxBurstDef)
            return longint'(MaxBurstDef);
        return longint'(maxclk_cfg);
    endfunction

    function automatic void emit_msg(input logic [7:0] st, input longint spp,
                                     input logic [31:0] wt);
        mcg_out_t    m;
        logic [31:0] b;
        b = spp[31:0];
        m = '0;
        m.msg_valid   = (st != ST_NONE);
        m.status_byte = st;
        if (st == ST_SPP)
        begin
            m.data_lsb   = b[6:0];
            m.data_msb   = b[13:7];
            m.data_count = SPP_DATA_CNT;
        end
        m.wait_pulses = wt;
        step_msgs.push_back(m);
    endfunction

    // work out the messages of one update and advance the model state
    function automatic void predict_update(input mcg_in_t it);
        longint      pos;
        longint      target;
        longint      beat;
        longint      cnt;
        longint      n;
        longint      cap;
        longint      b;
        logic [31:0] wt;
        bit          done;
        mcg_out_t    m;
        step_msgs.delete();
        pos    = longint'($signed(it.position));
        target = (pos + longint'(offs_cfg)) * 24;
        beat   = (pos * 4) / QONE;
        case (it.kind)
            KIND_POLL:
            begin
                if (run_model)
                begin
                    cnt = longint'($signed(pc_model));
                    n   = floor_pulses(target - cnt * QONE);
                    if (n < 0)
                        emit_msg(ST_NONE, 0, clamp_wait(cnt * QONE - target));
                    else
                    begin
                        cap = burst_limit();
                        if (n > cap)
                            n = cap;
                        pc_model = pc_model + n[31:0];
                        cnt      = longint'($signed(pc_model));
                        if (target < cnt * QONE)
                            wt = clamp_wait(cnt * QONE - target);
                        else if (target < (cnt + 1) * QONE)
                            wt = clamp_wait((cnt + 1) * QONE - target);
                        else
                            wt = '0;
                        for (longint i = 0; i < n; i++)
                            emit_msg(ST_CLOCK, 0, wt);
                        if (n == 0)
                            emit_msg(ST_NONE, 0, wt);
                    end
                end
            end
            KIND_START:
            begin
                run_model = 1'b1;
                cnt       = target / QONE;
                pc_model  = cnt[31:0];
            end
            KIND_STOP:
            begin
                run_model = 1'b0;
            end
            KIND_PLAY:
            begin
                done = 1'b0;
                // time jump: stop, song position, resume
                if (it.force_restart && spp_cfg)
                begin
                    if (longint'($signed(pc_model)) / 6 == beat)
                        done = 1'b1;
                    else
                    begin
                        if (it.transport_playing)
                            emit_msg(ST_STOP, 0, '0);
                        emit_msg(ST_SPP, beat, '0);
                        if (it.transport_playing)
                            emit_msg(beat > 0 ? ST_CONT : ST_START, 0, '0);
                        cnt      = beat * 6;
                        pc_model = cnt[31:0];
                    end
                end
                if (!done)
                begin
                    if (it.play_on)
                    begin
                        cnt = target / QONE;
                        b   = 0;
                        // catch-up clocks for a start below zero
                        if (cnt < 0)
                        begin
                            n   = -cnt;
                            cap = burst_limit();
                            if (cap > longint'(PLAY_CLK_MAX))
                                cap = longint'(PLAY_CLK_MAX);
                            if (n > cap)
                                n = cap;
                            for (longint i = 0; i < n; i++)
                                emit_msg(ST_CLOCK, 0, '0);
                        end
                        if (spp_cfg)
                        begin
                            b = beat;
                            emit_msg(ST_SPP, b, '0);
                        end
                        emit_msg(b > 0 ? ST_CONT : ST_START, 0, '0);
                        cnt      = b * 6;
                        pc_model = cnt[31:0];
                    end
                    else
                        emit_msg(ST_STOP, 0, '0);
                    play_model = it.play_on;
                end
            end
        endcase
        if (step_msgs.size() == 0)
            emit_msg(ST_NONE, 0, '0);
        m = step_msgs.pop_back();
        m.last = 1'b1;
        step_msgs.push_back(m);
    endfunction

    // ------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------
    function automatic void report(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    function automatic void check_msg(input mcg_out_t want, input mcg_out_t got);
        if (got.msg_valid !== want.msg_valid)
            report("msg_valid", 32'(want.msg_valid), 32'(got.msg_valid));
        if (got.status_byte !== want.status_byte)
            report("status_byte", 32'(want.status_byte), 32'(got.status_byte));
        if (got.data_lsb !== want.data_lsb)
            report("data_lsb", 32'(want.data_lsb), 32'(got.data_lsb));
        if (got.data_msb !== want.data_msb)
            report("data_msb", 32'(want.data_msb), 32'(got.data_msb));
        if (got.data_count !== want.data_count)
            report("data_count", 32'(want.data_count), 32'(got.data_count));
        if (got.wait_pulses !== want.wait_pulses)
            report("wait_pulses", want.wait_pulses, got.wait_pulses);
        if (got.last !== want.last)
            report("last", 32'(want.last), 32'(got.last));
    endfunction

    // results are scored before the update taken at the same edge is modeled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (msg_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing expected, status %h wait %h",
                             $time, out_item.status_byte, out_item.wait_pulses);
                end
                else
                    check_msg(msg_q.pop_front(), out_item);
            end
            if (in_valid && !in_stall)
            begin
                predict_update(in_item);
                if (row_typed)
                    msg_q.push_back(row_msg);
                else
                    foreach (step_msgs[i])
                        msg_q.push_back(step_msgs[i]);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r >= 50)
                begin
                    out_stall <= 1'b1;
                    if (r < 88)
                        repeat ($urandom_range(1, 3)) @(posedge clk);
                    else if (r < 97)
                        repeat ($urandom_range(4, 12)) @(posedge clk);
                    else
                        repeat ($urandom_range(20, 60)) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic mcg_in_t mk_item(input logic [1:0] kind, input logic [31:0] pos,
                                        input logic po, input logic fr, input logic tp);
        mcg_in_t it;
        it.kind              = kind;
        it.position          = pos;
        it.play_on           = po;
        it.force_restart     = fr;
        it.transport_playing = tp;
        return it;
    endfunction

    // offer one update and hold it until the block takes the transaction
    task automatic offer(input mcg_in_t it, input logic typed, input mcg_out_t tmsg);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_item   <= it;
        row_typed <= typed;
        row_msg   <= tmsg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send(input logic [1:0] kind, input logic [31:0] pos,
                        input logic po, input logic fr, input logic tp);
        offer(mk_item(kind, pos, po, fr, tp), 1'b0, '0);
    endtask

    // wait until every expected message has come back and the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (msg_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] offs, input logic [31:0] spp_word,
                                input logic [31:0] max_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_OFFSET;
        cfg_wdata <= offs;
        @(posedge clk);
        cfg_index <= CFG_SPP_EN;
        cfg_wdata <= spp_word;
        @(posedge clk);
        cfg_index <= CFG_MAX_CLK;
        cfg_wdata <= max_word;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        offs_cfg   = offs;
        spp_cfg    = spp_word[0];
        maxclk_cfg = max_word[5:0];
    endtask

    // one transport session: start, play, polls with jumps and toggles, stop
    task automatic run_song();
        int          sp;
        int          last_jump;
        int          r;
        logic [31:0] pos;
        logic        po;
        if ($urandom_range(0, 9) == 0)
            sp = $urandom;
        else
            sp = int'($urandom_range(0, 'h18_0000)) - 'h4_0000;
        last_jump = sp;
        send(KIND_START, sp, 1'($urandom), 1'($urandom), 1'($urandom));
        send(KIND_PLAY, sp, 1'b1, 1'b0, 1'($urandom));
        repeat ($urandom_range(4, 16))
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                // playback advancing, now and then a large step or a step back
                if ($urandom_range(0, 7) == 0)
                    sp += int'($urandom_range(0, 'h10_0000));
                else if ($urandom_range(0, 9) == 0)
                    sp -= int'($urandom_range(0, 'h8000));
                else
                    sp += int'($urandom_range(0, 'h3000));
                send(KIND_POLL, sp, 1'($urandom), 1'($urandom), 1'($urandom));
            end
            else if (r < 72)
            begin
                // jump that lands in the sixteenth of the last jump
                if (last_jump >= 0)
                    pos = {last_jump[31:14], 14'($urandom)};
                else
                    pos = last_jump;
                send(KIND_PLAY, pos, 1'b1, 1'b1, ($urandom_range(0, 3) != 0));
            end
            else if (r < 84)
            begin
                sp = sp + int'($urandom_range(0, 'h10_0000)) - 'h8_0000;
                last_jump = sp;
                send(KIND_PLAY, sp, ($urandom_range(0, 3) != 0), 1'b1,
                     ($urandom_range(0, 3) != 0));
            end
            else if (r < 90)
            begin
                po = 1'($urandom);
                if (po)
                    last_jump = sp;
                send(KIND_PLAY, sp, po, 1'b0, 1'($urandom));
            end
            else if (r < 94)
            begin
                send(KIND_STOP, sp, 1'($urandom), 1'($urandom), 1'($urandom));
                send(KIND_START, sp, 1'($urandom), 1'($urandom), 1'($urandom));
            end
            else
                send(2'($urandom), $urandom, 1'($urandom), 1'($urandom), 1'($urandom));
        end
        send(KIND_PLAY, sp, 1'b0, 1'b0, 1'($urandom));
        send(KIND_STOP, sp, 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        mcg_out_t    tmsg;
        int          goal;
        logic [31:0] w_offs;
        logic [31:0] w_spp;
        logic [31:0] w_max;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scripted sequence on reset settings
        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            tmsg             = '0;
            tmsg.last        = 1'b1;
            tmsg.wait_pulses = SCRIPT[r].idle_wait;
            offer(mk_item(SCRIPT[r].kind, SCRIPT[r].pos, SCRIPT[r].play_on,
                          SCRIPT[r].force_rs, SCRIPT[r].tplay),
                  SCRIPT[r].typed, tmsg);
        end

        // random sessions under several register settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            w_spp = $urandom;
            w_max = $urandom;
            case (ph)
                0:
                begin
                    w_offs = 32'h0000_0000;
                    w_spp  = 32'd1;
                    w_max  = 32'd56;
                end
                1:
                begin
                    w_offs = 32'h7FFF_FFFF;
                    w_spp  = 32'd0;
                    w_max  = 32'd0;
                end
                2:
                begin
                    w_offs = 32'h8000_0000;
                    w_spp  = 32'd1;
                    w_max  = 32'd1;
                end
                3:
                begin
                    w_offs    = $urandom_range(0, 'h8_0000) - 'h4_0000;
                    w_spp[0]  = 1'b1;
                    w_max[5:0] = 6'($urandom_range(0, 56));
                end
                4:
                begin
                    w_offs     = $urandom;
                    w_max[5:0] = 6'($urandom_range(0, 56));
                end
                default:
                begin
                    w_offs     = -$urandom_range(0, 'h2_0000);
                    w_max[5:0] = MAX_CLK_RST;
                end
            endcase
            program_regs(w_offs, w_spp, w_max);
            calm     = (ph == 3);
            hold_req = (ph == 2);
            goal     = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                run_song();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && msg_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
